FILE: sv/mcos_pkg.sv
package mcos_pkg;

  localparam int unsigned RetryW = 4;
  localparam int unsigned TimerW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_QUERY_WAIT = 3'd1,
    PH_ACT_WAIT  = 3'd2,
    PH_OPEN_SEND = 3'd3,
    PH_OPEN_WAIT = 3'd4,
    PH_DONE      = 3'd5,
    PH_ERROR     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE     = 2'd0,
    CMD_QUERY    = 2'd1,
    CMD_ACTIVATE = 2'd2,
    CMD_OPEN     = 2'd3
  } cmd_t;

  localparam logic [1:0] RESP_OK = 2'd0;
  localparam logic [1:0] RESP_DATA = 2'd1;

  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVATE_TIMEOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_TIMEOUT = 2'd3;

  localparam logic [RetryW-1:0] RETRY_LIMIT_RESET = 4'd1;
  localparam logic [TimerW-1:0] TIMEOUT_RESET = 24'd1000;

  typedef struct packed {
    logic [RetryW-1:0] retry_limit;
    logic [TimerW-1:0] query_timeout;
    logic [TimerW-1:0] activate_timeout;
    logic [TimerW-1:0] open_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic              context_flag;
    logic [RetryW-1:0] retry_counter;
    logic [TimerW-1:0] timeout_count;
    logic              timeout_armed;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic       send_accepted;
    logic       response_ready;
    logic [1:0] response_code;
  } step_beat_t;

endpackage

FILE: sv/mcos_if.sv
interface mcos_step_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       send_accepted;
  logic       response_ready;
  logic [1:0] response_code;

  modport source(output valid, kind, send_accepted, response_ready, response_code,
                 input ready);
  modport sink(input valid, kind, send_accepted, response_ready, response_code,
               output ready);
endinterface

interface mcos_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] issue_command;
  logic [2:0] sequencer_state;
  logic       context_up;
  logic [3:0] retries_used;

  modport source(output valid, issue_command, sequencer_state, context_up, retries_used,
                 input ready);
  modport sink(input valid, issue_command, sequencer_state, context_up, retries_used,
               output ready);
endinterface

FILE: sv/mcos_step.sv
module mcos_step (
  input  mcos_pkg::state_t     cur,
  input  mcos_pkg::cfg_t       cfg,
  input  mcos_pkg::step_beat_t beat,
  output mcos_pkg::state_t     nxt,
  output mcos_pkg::cmd_t       cmd
);

  logic expired;

  // Retry from the given phase while retries remain, otherwise give up.
  function automatic mcos_pkg::state_t fail_to(input mcos_pkg::state_t s,
                                               input logic [mcos_pkg::RetryW-1:0] limit,
                                               input mcos_pkg::phase_t retry_phase);
    mcos_pkg::state_t r;
    r = s;
    if (s.retry_counter < limit) begin
      r.retry_counter = s.retry_counter + mcos_pkg::RetryW'(1);
      r.phase = retry_phase;
    end else begin
      r.phase = mcos_pkg::PH_ERROR;
    end
    return r;
  endfunction

  always_comb begin
    nxt = cur;
    cmd = mcos_pkg::CMD_NONE;
    expired = 1'b0;
    if (beat.kind == mcos_pkg::KIND_RESTART) begin
      nxt.phase = mcos_pkg::PH_IDLE;
      nxt.context_flag = 1'b0;
      nxt.retry_counter = '0;
      nxt.timeout_armed = 1'b0;
      nxt.timeout_count = '0;
    end else begin
      if (cur.timeout_armed) begin
        if (cur.timeout_count == '0) begin
          expired = 1'b1;
        end else begin
          nxt.timeout_count = cur.timeout_count - mcos_pkg::TimerW'(1);
        end
      end
      if (expired && (cur.phase == mcos_pkg::PH_QUERY_WAIT ||
                      cur.phase == mcos_pkg::PH_ACT_WAIT ||
                      cur.phase == mcos_pkg::PH_OPEN_WAIT)) begin
        nxt.timeout_armed = 1'b0;
        nxt = fail_to(nxt, cfg.retry_limit, mcos_pkg::PH_IDLE);
      end else begin
        unique case (cur.phase)
          mcos_pkg::PH_IDLE: begin
            if (!cur.context_flag) begin
              if (beat.send_accepted) begin
                cmd = mcos_pkg::CMD_QUERY;
                nxt.timeout_count = cfg.query_timeout;
                nxt.timeout_armed = 1'b1;
                nxt.phase = mcos_pkg::PH_QUERY_WAIT;
              end
            end else begin
              nxt.phase = mcos_pkg::PH_OPEN_SEND;
            end
          end
          mcos_pkg::PH_QUERY_WAIT: begin
            if (beat.response_ready) begin
              nxt.timeout_armed = 1'b0;
              if (beat.response_code == mcos_pkg::RESP_DATA) begin
                nxt.context_flag = 1'b1;
                nxt.retry_counter = '0;
                nxt.phase = mcos_pkg::PH_OPEN_SEND;
              end else if (beat.response_code == mcos_pkg::RESP_OK) begin
                // A rejected activate leaves the timer off and the phase as is.
                if (beat.send_accepted) begin
                  cmd = mcos_pkg::CMD_ACTIVATE;
                  nxt.timeout_count = cfg.activate_timeout;
                  nxt.timeout_armed = 1'b1;
                  nxt.phase = mcos_pkg::PH_ACT_WAIT;
                end
              end else begin
                nxt = fail_to(nxt, cfg.retry_limit, mcos_pkg::PH_IDLE);
              end
            end
          end
          mcos_pkg::PH_ACT_WAIT: begin
            if (beat.response_ready) begin
              nxt.timeout_armed = 1'b0;
              if (beat.response_code == mcos_pkg::RESP_OK) begin
                nxt.retry_counter = '0;
                nxt.phase = mcos_pkg::PH_OPEN_SEND;
              end else begin
                nxt = fail_to(nxt, cfg.retry_limit, mcos_pkg::PH_IDLE);
              end
            end
          end
          mcos_pkg::PH_OPEN_SEND: begin
            if (beat.send_accepted) begin
              cmd = mcos_pkg::CMD_OPEN;
              nxt.timeout_count = cfg.open_timeout;
              nxt.timeout_armed = 1'b1;
              nxt.phase = mcos_pkg::PH_OPEN_WAIT;
            end
          end
          mcos_pkg::PH_OPEN_WAIT: begin
            if (beat.response_ready) begin
              nxt.timeout_armed = 1'b0;
              if (beat.response_code == mcos_pkg::RESP_OK) begin
                nxt.context_flag = 1'b1;
                nxt.retry_counter = '0;
                nxt.phase = mcos_pkg::PH_DONE;
              end else begin
                nxt = fail_to(nxt, cfg.retry_limit, mcos_pkg::PH_OPEN_SEND);
              end
            end
          end
          default: begin
            // Done, error and the unused code hold until a restart.
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/modem_context_open_sequencer.sv
// Channel   Role    Beat payload
// step      sink    kind, send_accepted, response_ready, response_code
// result    source  issue_command, sequencer_state, context_up, retries_used
//
// One step beat yields one result beat. A beat is registered on entry, and the
// sequencer state and the result register then update together from the entry
// register, and a new step is taken every cycle while the result is not stalled.
// The whole step is a single pass through the state update logic; that path sets the rate.
// Reset is synchronous and returns the configuration registers to their defaults.
// A stalled result holds the entry register; step.ready drops only when both are full.
module modem_context_open_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  mcos_step_if.sink                       step,
  mcos_result_if.source                   result,
  input  logic                            cfg_wen,
  input  logic [mcos_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mcos_pkg::CfgDataW-1:0]   cfg_data
);

  mcos_pkg::cfg_t       cfg;
  mcos_pkg::state_t     state;
  mcos_pkg::state_t     state_next;
  mcos_pkg::cmd_t       step_cmd;
  mcos_pkg::step_beat_t beat;
  logic                 beat_valid;
  logic                 advance;
  logic                 res_valid;
  logic [1:0]           res_cmd;
  logic [2:0]           res_state;
  logic                 res_ctx;
  logic [3:0]           res_retries;

  assign advance = beat_valid && (!res_valid || result.ready);
  assign step.ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit <= mcos_pkg::RETRY_LIMIT_RESET;
      cfg.query_timeout <= mcos_pkg::TIMEOUT_RESET;
      cfg.activate_timeout <= mcos_pkg::TIMEOUT_RESET;
      cfg.open_timeout <= mcos_pkg::TIMEOUT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mcos_pkg::CFG_RETRY_LIMIT:      cfg.retry_limit <= cfg_data[mcos_pkg::RetryW-1:0];
        mcos_pkg::CFG_QUERY_TIMEOUT:    cfg.query_timeout <= cfg_data;
        mcos_pkg::CFG_ACTIVATE_TIMEOUT: cfg.activate_timeout <= cfg_data;
        mcos_pkg::CFG_OPEN_TIMEOUT:     cfg.open_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (step.ready) begin
      beat_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      beat.kind <= step.kind;
      beat.send_accepted <= step.send_accepted;
      beat.response_ready <= step.response_ready;
      beat.response_code <= step.response_code;
    end
  end

  mcos_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .beat (beat),
    .nxt  (state_next),
    .cmd  (step_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= mcos_pkg::PH_IDLE;
      state.context_flag <= 1'b0;
      state.retry_counter <= '0;
      state.timeout_count <= '0;
      state.timeout_armed <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_cmd <= step_cmd;
      res_state <= state_next.phase;
      res_ctx <= state_next.context_flag;
      res_retries <= state_next.retry_counter;
    end
  end

  assign result.valid = res_valid;
  assign result.issue_command = res_cmd;
  assign result.sequencer_state = res_state;
  assign result.context_up = res_ctx;
  assign result.retries_used = res_retries;

`ifndef SYNTHESIS
  // A restart beat always lands in idle with the flag and retry count cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && beat.kind == mcos_pkg::KIND_RESTART) |=>
      (result.sequencer_state == mcos_pkg::PH_IDLE && !result.context_up &&
       result.retries_used == '0))
    else $error("restart did not clear the sequencer");

  // A command goes out only on a stepping beat that the command layer accepts.
  a_cmd_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (advance && step_cmd != mcos_pkg::CMD_NONE) |->
      (beat.send_accepted && beat.kind == mcos_pkg::KIND_STEP))
    else $error("command issued without an accepted send");

  // Done is reached only with the context known active.
  a_done_has_context: assert property (@(posedge clk)
    (state.phase == mcos_pkg::PH_DONE) |-> state.context_flag)
    else $error("done without context flag");

  // The timer only runs while an answer is awaited.
  a_timer_in_wait: assert property (@(posedge clk)
    state.timeout_armed |-> (state.phase == mcos_pkg::PH_QUERY_WAIT ||
                             state.phase == mcos_pkg::PH_ACT_WAIT ||
                             state.phase == mcos_pkg::PH_OPEN_WAIT))
    else $error("timer armed outside a waiting phase");
`endif

endmodule
